/* sv/assert_macros.svh */
// Assertion macros used by the checker file rou_checker.sv.
// No dependencies; include guarded.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every edge, off while reset is low.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition that must hold at every edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

`endif

/* sv/rou_pkg.sv */
// Rectangle operation unit package: coordinate types, beat structs, codes
// and saturation helpers. No dependencies.
package rou_pkg;

	localparam int COORD_BITS = 16;
	// headroom for align sums: offset + half-difference + edge
	localparam int WIDE_BITS  = COORD_BITS + 3;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [WIDE_BITS-1:0]  wide_t;

	typedef logic [2:0] action_t;
	typedef logic [3:0] align_mode_t;

	localparam action_t ACT_INTERSECT = 3'd0;
	localparam action_t ACT_UNION     = 3'd1;
	localparam action_t ACT_SUBTRACT  = 3'd2;
	localparam action_t ACT_OFFSET    = 3'd3;
	localparam action_t ACT_CONTAINS  = 3'd4;
	localparam action_t ACT_ALIGN     = 3'd5;

	localparam align_mode_t AL_LEFT          = 4'd0;
	localparam align_mode_t AL_TOP           = 4'd1;
	localparam align_mode_t AL_RIGHT         = 4'd2;
	localparam align_mode_t AL_BOTTOM        = 4'd3;
	localparam align_mode_t AL_LEFT_TOP      = 4'd4;
	localparam align_mode_t AL_RIGHT_TOP     = 4'd5;
	localparam align_mode_t AL_LEFT_BOTTOM   = 4'd6;
	localparam align_mode_t AL_RIGHT_BOTTOM  = 4'd7;
	localparam align_mode_t AL_LEFT_CENTER   = 4'd8;
	localparam align_mode_t AL_TOP_CENTER    = 4'd9;
	localparam align_mode_t AL_RIGHT_CENTER  = 4'd10;
	localparam align_mode_t AL_BOTTOM_CENTER = 4'd11;
	localparam align_mode_t AL_CENTER_HORIZ  = 4'd12;
	localparam align_mode_t AL_CENTER_VERT   = 4'd13;
	localparam align_mode_t AL_CENTER        = 4'd14;

	typedef struct packed {
		coord_t l;
		coord_t t;
		coord_t r;
		coord_t b;
	} rect_t;

	typedef struct packed {
		action_t     action;
		coord_t      a_left;
		coord_t      a_top;
		coord_t      a_right;
		coord_t      a_bottom;
		coord_t      b_left;
		coord_t      b_top;
		coord_t      b_right;
		coord_t      b_bottom;
		coord_t      x_operand;
		coord_t      y_operand;
		align_mode_t align_mode;
	} cmd_t;

	typedef struct packed {
		coord_t res_left;
		coord_t res_top;
		coord_t res_right;
		coord_t res_bottom;
		logic   ok;
	} res_t;

	localparam wide_t WIDE_MAX = wide_t'({1'b0, {(COORD_BITS-1){1'b1}}});
	localparam wide_t WIDE_MIN = -WIDE_MAX - wide_t'(1);

	function automatic wide_t widen(input coord_t v);
		return wide_t'(v);
	endfunction

	function automatic coord_t sat(input wide_t v);
		wide_t c;
		if (v > WIDE_MAX)
			c = WIDE_MAX;
		else if (v < WIDE_MIN)
			c = WIDE_MIN;
		else
			c = v;
		return coord_t'(c[COORD_BITS-1:0]);
	endfunction

	function automatic logic nonempty(input rect_t v);
		return (v.r > v.l) && (v.b > v.t);
	endfunction

endpackage

/* sv/rectangle_operation_unit_top.sv */
// Rectangle operation unit, top level: input register, datapath, result register.
// Depends on rou_pkg and rou_core.
//
// channel   direction  handshake            payload
// command   in         start, busy          cmd    (rou_pkg::cmd_t)
// result    out        done (one-cycle)     result (rou_pkg::res_t)
//
// One beat per cycle; each command beat is registered in item_s1, and its result in result_s2.
// Throughput is set by the single pass through rou_core between the two registers.
// busy stays low: the pipe never holds, since the result side cannot stall.
// Asynchronous reset clears the valid flags only; payload registers are not reset.
module rectangle_operation_unit_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  rou_pkg::cmd_t  cmd,
	output logic           done,
	output rou_pkg::res_t  result
);
	import rou_pkg::*;

	cmd_t item_s1;
	logic valid_s1;
	res_t res_comb, result_s2;
	logic done_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_s2  <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			done_s2  <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy)
			item_s1 <= cmd;
		if (valid_s1)
			result_s2 <= res_comb;
	end

	rou_core u_core (
		.cmd (item_s1),
		.res (res_comb)
	);

	assign done   = done_s2;
	assign result = result_s2;

endmodule

/* sv/rou_align.sv */
// Align datapath: moves rectangle B against rectangle A by mode.
// Depends on rou_pkg.
module rou_align (
	input  rou_pkg::rect_t       a,
	input  rou_pkg::rect_t       b,
	input  rou_pkg::align_mode_t mode,
	output rou_pkg::rect_t       res,
	output logic                 ok
);
	import rou_pkg::*;

	wide_t ox1, oy1, ox2, oy2, hw, hh, dw, dh, dx, dy;

	always_comb begin
		ox1 = widen(a.l) - widen(b.l);
		oy1 = widen(a.t) - widen(b.t);
		ox2 = widen(a.r) - widen(b.r);
		oy2 = widen(a.b) - widen(b.b);
		dw  = (widen(a.r) - widen(a.l)) - (widen(b.r) - widen(b.l));
		dh  = (widen(a.b) - widen(a.t)) - (widen(b.b) - widen(b.t));
		// arithmetic shift rounds toward minus infinity
		hw  = dw >>> 1;
		hh  = dh >>> 1;
		dx  = '0;
		dy  = '0;
		ok  = 1'b1;
		unique case (mode)
			AL_LEFT:          dx = ox1;
			AL_TOP:           dy = oy1;
			AL_RIGHT:         dx = ox2;
			AL_BOTTOM:        dy = oy2;
			AL_LEFT_TOP: begin
				dx = ox1; dy = oy1;
			end
			AL_RIGHT_TOP: begin
				dx = ox2; dy = oy1;
			end
			AL_LEFT_BOTTOM: begin
				dx = ox1; dy = oy2;
			end
			AL_RIGHT_BOTTOM: begin
				dx = ox2; dy = oy2;
			end
			AL_LEFT_CENTER: begin
				dx = ox1; dy = oy1 + hh;
			end
			AL_TOP_CENTER: begin
				dx = ox1 + hw; dy = oy1;
			end
			AL_RIGHT_CENTER: begin
				dx = ox2; dy = oy1 + hh;
			end
			AL_BOTTOM_CENTER: begin
				dx = ox1 + hw; dy = oy2;
			end
			AL_CENTER_HORIZ:  dx = ox1 + hw;
			AL_CENTER_VERT:   dy = oy1 + hh;
			AL_CENTER: begin
				dx = ox1 + hw; dy = oy1 + hh;
			end
			default:          ok = 1'b0;
		endcase
	end

	always_comb begin
		if (ok) begin
			res.l = sat(widen(b.l) + dx);
			res.r = sat(widen(b.r) + dx);
			res.t = sat(widen(b.t) + dy);
			res.b = sat(widen(b.b) + dy);
		end else begin
			res = b;
		end
	end

endmodule

/* sv/rou_core.sv */
// Rectangle operation datapath: set operations, subtract, offset, point test,
// align and result select. Depends on rou_pkg and rou_align.
module rou_core (
	input  rou_pkg::cmd_t cmd,
	output rou_pkg::res_t res
);
	import rou_pkg::*;

	rect_t a, b, ix, un, sub, off, al_res, pick;
	logic  al_ok, pt_hit, ok;

	assign a = '{l: cmd.a_left, t: cmd.a_top, r: cmd.a_right, b: cmd.a_bottom};
	assign b = '{l: cmd.b_left, t: cmd.b_top, r: cmd.b_right, b: cmd.b_bottom};

	rou_align u_align (
		.a    (a),
		.b    (b),
		.mode (cmd.align_mode),
		.res  (al_res),
		.ok   (al_ok)
	);

	always_comb begin
		ix.l = (a.l > b.l) ? a.l : b.l;
		ix.t = (a.t > b.t) ? a.t : b.t;
		ix.r = (a.r < b.r) ? a.r : b.r;
		ix.b = (a.b < b.b) ? a.b : b.b;
		un.l = (a.l < b.l) ? a.l : b.l;
		un.t = (a.t < b.t) ? a.t : b.t;
		un.r = (a.r > b.r) ? a.r : b.r;
		un.b = (a.b > b.b) ? a.b : b.b;
	end

	// subtract keeps only a single strip left over when B takes an edge band
	always_comb begin
		sub = '0;
		if (nonempty(ix)) begin
			priority if (ix.l == a.l && ix.t == a.t) begin
				priority if (ix.b == a.b)
					sub = '{l: ix.r, t: ix.t, r: a.r, b: ix.b};
				else if (ix.r == a.r)
					sub = '{l: ix.l, t: ix.b, r: ix.r, b: a.b};
				else
					sub = '0;
			end else if (ix.r == a.r && ix.b == a.b) begin
				priority if (ix.l == a.l)
					sub = '{l: ix.l, t: a.t, r: ix.r, b: ix.t};
				else if (ix.t == a.t)
					sub = '{l: a.l, t: ix.t, r: ix.l, b: ix.b};
				else
					sub = '0;
			end else begin
				sub = '0;
			end
		end
	end

	always_comb begin
		off.l = sat(widen(a.l) + widen(cmd.x_operand));
		off.r = sat(widen(a.r) + widen(cmd.x_operand));
		off.t = sat(widen(a.t) + widen(cmd.y_operand));
		off.b = sat(widen(a.b) + widen(cmd.y_operand));
		pt_hit = (cmd.x_operand >= a.l) && (cmd.x_operand < a.r) &&
			(cmd.y_operand >= a.t) && (cmd.y_operand < a.b);
	end

	always_comb begin
		pick = '0;
		ok   = 1'b0;
		unique case (cmd.action)
			ACT_INTERSECT: begin
				ok   = nonempty(ix);
				pick = ok ? ix : '0;
			end
			ACT_UNION: begin
				ok   = nonempty(un);
				pick = ok ? un : '0;
			end
			ACT_SUBTRACT: begin
				ok   = nonempty(sub);
				pick = ok ? sub : '0;
			end
			ACT_OFFSET: begin
				ok   = 1'b1;
				pick = off;
			end
			ACT_CONTAINS:  ok = pt_hit;
			ACT_ALIGN: begin
				ok   = al_ok;
				pick = al_res;
			end
			default: begin
				ok   = 1'b0;
				pick = '0;
			end
		endcase
	end

	assign res = '{res_left: pick.l, res_top: pick.t, res_right: pick.r,
		res_bottom: pick.b, ok: ok};

endmodule

/* sv/rou_checker.sv */
// Port-level checker for the rectangle operation unit, with its bind.
// Depends on rou_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rou_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input rou_pkg::cmd_t cmd,
	input logic          done,
	input rou_pkg::res_t result
);
	import rou_pkg::*;

	logic acc;
	assign acc = start && !busy;

	// every command beat yields a result, and no result comes without a command beat
	`ASSERT_IMPLY(a_beat_to_result, clk, arst_n, acc, ##2 done, "command beat lost")
	`ASSERT_IMPLY(a_no_spurious, clk, arst_n, done, $past(acc, 2), "result without command")
	// a nonempty intersection is a proper rectangle
	`ASSERT_IMPLY(a_isect_shape, clk, arst_n,
		done && result.ok && $past(cmd.action, 2) == ACT_INTERSECT,
		result.res_left < result.res_right && result.res_top < result.res_bottom,
		"intersection flagged ok but empty")
	// point test leaves the rectangle fields at zero
	`ASSERT_IMPLY(a_contains_zero, clk, arst_n,
		done && $past(cmd.action, 2) == ACT_CONTAINS,
		result.res_left == 0 && result.res_top == 0 &&
		result.res_right == 0 && result.res_bottom == 0,
		"point test gave nonzero rectangle")

endmodule

bind rectangle_operation_unit_top rou_checker u_rou_checker (.*);
